// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check themselves (so far only the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WFPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define WFPC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/wfpc_pkg.sv -----
// Shared types and constants of the wave file parser and converter.
package wfpc_pkg;

  localparam logic [29:0] MAX_FILE_BYTES = 30'd536870912;
  localparam int          MaxChannels    = 32;
  localparam logic [31:0] MAX_FRAMES     = 32'd4194304;
  localparam int          FramesW        = 23;

  localparam logic [31:0] TAG_RIFF = 32'h46464952;
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] FMT_EXT   = 16'hFFFE;

  // Parse phases.
  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_CHDR = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_PAD  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_TAIL = 3'd5;

  // Status codes.
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SIZE    = 4'd1;
  localparam logic [3:0] ST_NOTRIFF = 4'd2;
  localparam logic [3:0] ST_MISSING = 4'd3;
  localparam logic [3:0] ST_CHANS   = 4'd4;
  localparam logic [3:0] ST_RATE    = 4'd5;
  localparam logic [3:0] ST_FORMAT  = 4'd6;
  localparam logic [3:0] ST_DEPTH   = 4'd7;
  localparam logic [3:0] ST_EMPTY   = 4'd8;
  localparam logic [3:0] ST_LONG    = 4'd9;

  localparam logic       ITEM_SAMPLE = 1'b0;
  localparam logic       ITEM_STATUS = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
    logic norm_step;
    logic div_finish;
    logic load_sample;
    logic load_status;
  } wfpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic smp;
    logic st_valid;
    logic pend_st;
    logic norm_done;
    logic div_done;
    logic div_bad;
  } wfpc_stat_t;

endpackage

// ----- hw/rtl/wave_file_parse_convert.sv -----
// Top level of the RIFF/WAVE byte parser and sample converter.
// Usage: write the file size to register file_length (address 0) over the
// APB-style port, then stream the file one byte per request on in_*.
// Each result request on out_* is a sample (tuser[0] = 0) as an IEEE
// double with its channel and frame-end mark, or the one final status
// (tuser[0] = 1) with the code, rate and channel count from fmt.
// One byte is handled at a time. The data chunk header also waits for the
// bit-serial frame-count divider. A byte that completes a sample waits for
// the one-bit-per-cycle normalizer, which shifts once per leading-zero bit.
// A status is loaded in a state of its own after the byte or sample it follows.
// While a result waits on out_tready, in_tready stays low and no result is
// ever dropped. After the status all further bytes are taken and dropped.
// Reset clears the parser, returns file_length to zero and withdraws any
// offered result.
`include "assert_macros.svh"

module wave_file_parse_convert import wfpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] file_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] sample_value, [68:64] channel_index, [72:69] status_code,
  // [92:73] rate_found, [98:93] channels_found, [103:99] zero
  output logic [103:0] out_tdata,
  output logic [1:0]   out_tuser,  // [0] item_kind, [1] frame_end
  output logic         out_tlast,  // run_last
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  wfpc_cmd_t   cmd;
  wfpc_stat_t  stat;
  logic        cfg_we;
  logic [29:0] cfg_rdata;
  logic        o_kind, o_fe, o_last;
  logic [63:0] o_val;
  logic [4:0]  o_ch;
  logic [3:0]  o_code;
  logic [19:0] o_rate;
  logic [5:0]  o_chans;
  logic        out_is_status, status_payload;

  // Register write on the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 3'd0);
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {2'b00, cfg_rdata} : 32'd0;

  wfpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  wfpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_pwdata[29:0]),
    .cfg_rdata (cfg_rdata),
    .o_kind    (o_kind),
    .o_val     (o_val),
    .o_ch      (o_ch),
    .o_fe      (o_fe),
    .o_code    (o_code),
    .o_rate    (o_rate),
    .o_chans   (o_chans),
    .o_last    (o_last)
  );

  assign out_tdata = {5'd0, o_chans, o_rate, o_code, o_ch, o_val};
  assign out_tuser = {o_fe, o_kind};
  assign out_tlast = o_last;

  // Status request and the sample fields it must leave clear.
  assign out_is_status  = out_tvalid && out_tuser[0];
  assign status_payload = (out_tdata[68:0] != 69'd0) || out_tuser[1];

  // One byte at a time: never take a byte while a result is offered.
  `WFPC_NEVER(a_one_at_a_time, in_tready && out_tvalid, "byte taken while result pending")
  // A status request always closes the run.
  `WFPC_ASSERT(a_status_last, out_is_status |-> out_tlast, "status not last")
  // A status request carries no sample, channel or frame mark.
  `WFPC_NEVER(a_status_clean, out_is_status && status_payload, "status with sample payload")

endmodule

// ----- hw/rtl/wfpc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the frame count.
module wfpc_div import wfpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] q_r, q_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [8:0]  dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [9:0]  rem_sh;

  // One shift and trial subtract per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_sh   = {rem_r[8:0], q_r[31]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r && !cnt_r[5]) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = busy_r && cnt_r[5];
  assign quot = q_r;

endmodule

// ----- hw/rtl/wfpc_dp.sv -----
// Datapath: parser state, fmt fields, sample assembly, conversion and output register.
module wfpc_dp import wfpc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  wfpc_cmd_t    cmd,
  output wfpc_stat_t   stat,
  input  logic [7:0]   in_byte,
  input  logic         cfg_we,
  input  logic [29:0]  cfg_wdata,
  output logic [29:0]  cfg_rdata,
  output logic         o_kind,
  output logic [63:0]  o_val,
  output logic [4:0]   o_ch,
  output logic         o_fe,
  output logic [3:0]   o_code,
  output logic [19:0]  o_rate,
  output logic [5:0]   o_chans,
  output logic         o_last
);

  logic [29:0] len_r;
  logic [29:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] left_r, left_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bps_r, bps_nxt;
  logic        seen_r, seen_nxt;
  logic [FramesW-1:0] frames_r, frames_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [3:0]  sbc_r, sbc_nxt;
  logic [4:0]  chc_r, chc_nxt;
  logic        fin_r, fin_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  pcode_r, pcode_nxt;

  // Conversion registers.
  logic [63:0] cv_raw_r;
  logic        cv_sign_r;
  logic [31:0] norm_r;
  logic [4:0]  k_r;
  logic        nn_r;
  logic [4:0]  cv_ch_r;
  logic        cv_fe_r;

  logic        st_v, smp, need_div, fe;
  logic [3:0]  st_c, fcode;
  logic [63:0] raw;
  logic [29:0] pos_inc;
  logic [31:0] room, idx, quot;
  logic [2:0]  hidx;
  logic [31:0] tag_sh;
  logic        capture, div_done;
  logic [8:0]  block;

  logic [31:0] xs, mag, norm_init;
  logic        nn_init;
  logic [63:0] smp_val;
  logic [10:0] pexp;

  // Format checks made at the data chunk header.
  always_comb begin
    fcode = ST_OK;
    if (chan_r < 16'd1 || chan_r > 16'(MaxChannels)) begin
      fcode = ST_CHANS;
    end else if (rate_r < 32'd8000 || rate_r > 32'd1000000) begin
      fcode = ST_RATE;
    end else if (fmt_r != FMT_PCM && fmt_r != FMT_FLOAT) begin
      fcode = ST_FORMAT;
    end else if (fmt_r == FMT_FLOAT) begin
      if (bps_r != 16'd32 && bps_r != 16'd64) fcode = ST_DEPTH;
    end else if (bps_r != 16'd16 && bps_r != 16'd24 && bps_r != 16'd32) begin
      fcode = ST_DEPTH;
    end
  end

  assign block = 9'(bps_r[6:3] * chan_r[5:0]);

  // Parser step for one byte, and the frame count once the divider is done.
  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    clen_nxt   = clen_r;
    left_nxt   = left_r;
    fmt_nxt    = fmt_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bps_nxt    = bps_r;
    seen_nxt   = seen_r;
    frames_nxt = frames_r;
    asm_nxt    = asm_r;
    sbc_nxt    = sbc_r;
    chc_nxt    = chc_r;
    fin_nxt    = fin_r;
    pend_nxt   = pend_r;
    pcode_nxt  = pcode_r;
    st_v       = 1'b0;
    st_c       = ST_OK;
    smp        = 1'b0;
    need_div   = 1'b0;
    fe         = 1'b0;
    raw        = asm_r;
    pos_inc    = pos_r + 30'd1;
    room       = '0;
    idx        = clen_r - left_r;
    hidx       = 3'd0 - left_r[2:0];
    tag_sh     = {in_byte, tag_r[31:8]};
    capture    = (tag_r == TAG_FMT) && (clen_r >= 32'd16);

    if (cmd.step && !fin_r) begin
      if (len_r == '0 || len_r > MAX_FILE_BYTES) begin
        st_v = 1'b1;
        st_c = ST_SIZE;
      end else begin
        pos_nxt = pos_inc;
        unique case (phase_r)
          PH_HDR: begin
            if (pos_r < 30'd4 || (pos_r >= 30'd8 && pos_r < 30'd12)) tag_nxt = tag_sh;
            if (pos_r == 30'd3 && tag_nxt != TAG_RIFF) begin
              st_v = 1'b1;
              st_c = ST_NOTRIFF;
            end else if (pos_r == 30'd11) begin
              if (tag_nxt != TAG_WAVE) begin
                st_v = 1'b1;
                st_c = ST_NOTRIFF;
              end else if ({1'b0, pos_inc} + 31'd8 <= {1'b0, len_r}) begin
                phase_nxt = PH_CHDR;
                left_nxt  = 32'd8;
                tag_nxt   = '0;
                clen_nxt  = '0;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
          end
          PH_CHDR: begin
            if (!hidx[2]) tag_nxt = tag_sh;
            else clen_nxt = clen_r | ({24'd0, in_byte} << {hidx[1:0], 3'b000});
            left_nxt = left_r - 32'd1;
            if (left_nxt == '0) begin
              if (len_r > pos_inc) room = {2'b00, len_r - pos_inc};
              if (clen_nxt > room) clen_nxt = room;
              if (tag_nxt == TAG_DATA) begin
                if (!seen_r) begin
                  st_v = 1'b1;
                  st_c = ST_MISSING;
                end else if (fcode != ST_OK) begin
                  st_v = 1'b1;
                  st_c = fcode;
                end else begin
                  need_div  = 1'b1;
                  phase_nxt = PH_DATA;
                  asm_nxt   = '0;
                  sbc_nxt   = '0;
                  chc_nxt   = '0;
                end
              end else begin
                if (tag_nxt == TAG_FMT && clen_nxt >= 32'd16) seen_nxt = 1'b1;
                asm_nxt = '0;
                if (clen_nxt == '0) begin
                  // An empty chunk has no body and no pad byte.
                  if ({1'b0, pos_inc} + 31'd8 <= {1'b0, len_r}) begin
                    phase_nxt = PH_CHDR;
                    left_nxt  = 32'd8;
                    tag_nxt   = '0;
                    clen_nxt  = '0;
                  end else begin
                    phase_nxt = PH_TAIL;
                  end
                end else begin
                  phase_nxt = PH_BODY;
                  left_nxt  = clen_nxt;
                end
              end
            end
          end
          PH_BODY: begin
            if (capture) begin
              if (idx == 32'd0) fmt_nxt = {8'd0, in_byte};
              else if (idx == 32'd1) fmt_nxt = {in_byte, fmt_r[7:0]};
              else if (idx == 32'd2) chan_nxt = {8'd0, in_byte};
              else if (idx == 32'd3) chan_nxt = {in_byte, chan_r[7:0]};
              else if (idx == 32'd4) rate_nxt = {24'd0, in_byte};
              else if (idx == 32'd5) rate_nxt = rate_r | {16'd0, in_byte, 8'd0};
              else if (idx == 32'd6) rate_nxt = rate_r | {8'd0, in_byte, 16'd0};
              else if (idx == 32'd7) rate_nxt = rate_r | {in_byte, 24'd0};
              else if (idx == 32'd14) bps_nxt = {8'd0, in_byte};
              else if (idx == 32'd15) bps_nxt = {in_byte, bps_r[7:0]};
              else if (idx == 32'd24) asm_nxt = {56'd0, in_byte};
              else if (idx == 32'd25) asm_nxt = asm_r | {48'd0, in_byte, 8'd0};
            end
            left_nxt = left_r - 32'd1;
            if (left_nxt == '0) begin
              // Extensible fmt: the subformat GUID carries the real format.
              if (capture && fmt_nxt == FMT_EXT && clen_r >= 32'd40) fmt_nxt = asm_nxt[15:0];
              if (clen_r[0]) begin
                phase_nxt = PH_PAD;
              end else if ({1'b0, pos_inc} + 31'd8 <= {1'b0, len_r}) begin
                phase_nxt = PH_CHDR;
                left_nxt  = 32'd8;
                tag_nxt   = '0;
                clen_nxt  = '0;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
          end
          PH_PAD: begin
            if ({1'b0, pos_inc} + 31'd8 <= {1'b0, len_r}) begin
              phase_nxt = PH_CHDR;
              left_nxt  = 32'd8;
              tag_nxt   = '0;
              clen_nxt  = '0;
            end else begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_DATA: begin
            asm_nxt = asm_r | ({56'd0, in_byte} << {sbc_r[2:0], 3'b000});
            sbc_nxt = sbc_r + 4'd1;
            if ({9'd0, sbc_nxt} >= bps_r[15:3]) begin
              smp     = 1'b1;
              raw     = asm_nxt;
              fe      = ({12'd0, chc_r} + 17'd1 >= {1'b0, chan_r});
              asm_nxt = '0;
              sbc_nxt = '0;
              chc_nxt = chc_r + 5'd1;
              if (fe) begin
                chc_nxt = '0;
                if (frames_r != '0) frames_nxt = frames_r - FramesW'(1);
                if (frames_nxt == '0) begin
                  st_v = 1'b1;
                  st_c = ST_OK;
                end
              end
            end
          end
          default: begin
          end
        endcase
        // File end reached without a finished parse.
        if (!st_v && !need_div && pos_inc >= len_r) begin
          st_v = 1'b1;
          st_c = (phase_nxt == PH_HDR) ? ST_NOTRIFF : ST_MISSING;
        end
      end
    end

    if (cmd.div_finish) begin
      if (quot == '0) begin
        st_v = 1'b1;
        st_c = ST_EMPTY;
      end else if (quot > MAX_FRAMES) begin
        st_v = 1'b1;
        st_c = ST_LONG;
      end else begin
        frames_nxt = quot[FramesW-1:0];
      end
    end

    if (st_v) begin
      fin_nxt   = 1'b1;
      pend_nxt  = 1'b1;
      pcode_nxt = st_c;
    end
    if (cmd.load_status) pend_nxt = 1'b0;
  end

  wfpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (need_div),
    .dividend (clen_nxt),
    .divisor  (block),
    .done     (div_done),
    .quot     (quot)
  );

  // Starting point of the normalizer for a new sample.
  always_comb begin
    unique case (bps_r[5:3])
      3'd2:    xs = {{16{raw[15]}}, raw[15:0]};
      3'd3:    xs = {{8{raw[23]}}, raw[23:0]};
      default: xs = raw[31:0];
    endcase
    mag = xs[31] ? (32'd0 - xs) : xs;
    if (fmt_r == FMT_FLOAT) begin
      norm_init = {1'b0, raw[22:0], 8'd0};
      nn_init   = (bps_r == 16'd32) && (raw[30:23] == 8'd0) && (raw[22:0] != 23'd0);
    end else begin
      norm_init = mag;
      nn_init   = (mag != '0);
    end
  end

  // Sample value once normalization is done.
  always_comb begin
    unique case (bps_r[5:3])
      3'd2:    pexp = 11'd1054 - {6'd0, k_r} - 11'd15;
      3'd3:    pexp = 11'd1054 - {6'd0, k_r} - 11'd23;
      default: pexp = 11'd1054 - {6'd0, k_r} - 11'd31;
    endcase
    if (fmt_r == FMT_FLOAT) begin
      if (bps_r == 16'd64) begin
        smp_val = cv_raw_r;
      end else if (cv_raw_r[30:23] == 8'hFF) begin
        smp_val = {cv_raw_r[31], 11'h7FF, cv_raw_r[22:0], 29'd0};
        if (cv_raw_r[22:0] != 23'd0) smp_val[51] = 1'b1;
      end else if (cv_raw_r[30:23] == 8'd0) begin
        if (cv_raw_r[22:0] == 23'd0) smp_val = {cv_raw_r[31], 63'd0};
        else smp_val = {cv_raw_r[31], 11'd897 - {6'd0, k_r}, norm_r[30:8], 29'd0};
      end else begin
        smp_val = {cv_raw_r[31], {3'd0, cv_raw_r[30:23]} + 11'd896, cv_raw_r[22:0], 29'd0};
      end
    end else if (!nn_r) begin
      smp_val = '0;
    end else begin
      smp_val = {cv_sign_r, pexp, norm_r[30:0], 21'd0};
    end
  end

  // Parser state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      pos_r    <= '0;
      phase_r  <= PH_HDR;
      tag_r    <= '0;
      clen_r   <= '0;
      left_r   <= '0;
      fmt_r    <= '0;
      chan_r   <= '0;
      rate_r   <= '0;
      bps_r    <= '0;
      seen_r   <= 1'b0;
      frames_r <= '0;
      asm_r    <= '0;
      sbc_r    <= '0;
      chc_r    <= '0;
      fin_r    <= 1'b0;
      pend_r   <= 1'b0;
      pcode_r  <= ST_OK;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      tag_r    <= tag_nxt;
      clen_r   <= clen_nxt;
      left_r   <= left_nxt;
      fmt_r    <= fmt_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bps_r    <= bps_nxt;
      seen_r   <= seen_nxt;
      frames_r <= frames_nxt;
      asm_r    <= asm_nxt;
      sbc_r    <= sbc_nxt;
      chc_r    <= chc_nxt;
      fin_r    <= fin_nxt;
      pend_r   <= pend_nxt;
      pcode_r  <= pcode_nxt;
    end
  end

  // Normalizer: one left shift per cycle until the top bit is set.
  always_ff @(posedge clk) begin
    if (cmd.step && smp) begin
      cv_raw_r  <= raw;
      cv_sign_r <= xs[31];
      norm_r    <= norm_init;
      k_r       <= '0;
      nn_r      <= nn_init;
      cv_ch_r   <= chc_r;
      cv_fe_r   <= fe;
    end else if (cmd.norm_step) begin
      norm_r <= {norm_r[30:0], 1'b0};
      k_r    <= k_r + 5'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      o_kind  <= ITEM_SAMPLE;
      o_val   <= smp_val;
      o_ch    <= cv_ch_r;
      o_fe    <= cv_fe_r;
      o_code  <= ST_OK;
      o_rate  <= '0;
      o_chans <= '0;
      o_last  <= !pend_r;
    end else if (cmd.load_status) begin
      o_kind  <= ITEM_STATUS;
      o_val   <= '0;
      o_ch    <= '0;
      o_fe    <= 1'b0;
      o_code  <= pcode_r;
      o_rate  <= rate_r[19:0];
      o_chans <= chan_r[5:0];
      o_last  <= 1'b1;
    end
  end

  assign cfg_rdata      = len_r;
  assign stat.need_div  = need_div;
  assign stat.smp       = smp;
  assign stat.st_valid  = st_v;
  assign stat.pend_st   = pend_r;
  assign stat.norm_done = !nn_r || norm_r[31];
  assign stat.div_done  = div_done;
  assign stat.div_bad   = (quot == '0) || (quot > MAX_FRAMES);

endmodule

// ----- hw/rtl/wfpc_ctrl.sv -----
// Controller state machine sequencing byte steps, division, conversion and output.
module wfpc_ctrl import wfpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  wfpc_stat_t stat,
  output wfpc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_OUT1 = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;
  localparam logic [2:0] S_OUT2 = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.step = 1'b1;
          priority if (stat.need_div) state_nxt = S_DIV;
          else if (stat.smp) state_nxt = S_NORM;
          else if (stat.st_valid) state_nxt = S_STAT;
          else state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_finish = 1'b1;
          state_nxt = stat.div_bad ? S_STAT : S_IDLE;
        end
      end
      S_NORM: begin
        if (stat.norm_done) begin
          cmd.load_sample = 1'b1;
          state_nxt = S_OUT1;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_OUT1: begin
        if (out_tready) state_nxt = stat.pend_st ? S_STAT : S_IDLE;
      end
      S_STAT: begin
        cmd.load_status = 1'b1;
        state_nxt = S_OUT2;
      end
      S_OUT2: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT1) || (state_r == S_OUT2);

endmodule
